FILE: rtl/hsfd_pkg.sv
// shared types, constants and helper functions for the humidity sensor frame decoder
// no dependencies
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TOTAL_W         = 32;
    localparam int FRAME_W         = 48;
    localparam int WORD_W          = 20;
    localparam int TEMP_W          = 15;
    localparam int RH_W            = 14;
    localparam int T_COEF_W        = 15;
    localparam int H_COEF_W        = 14;
    localparam int T_PROD_W        = T_COEF_W + WORD_W;
    localparam int H_PROD_W        = H_COEF_W + WORD_W;
    localparam int PACKED_SHIFT    = 20;

    localparam logic       SENSOR_CRC_PAIR = 1'b0;
    localparam logic       SENSOR_PACKED   = 1'b1;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [15:0]         FULL_SCALE     = 16'd65535;
    localparam logic [T_COEF_W-1:0] T_COEF_CRC     = 15'd17500;
    localparam logic [T_COEF_W-1:0] T_COEF_PACKED  = 15'd20000;
    localparam logic [H_COEF_W-1:0] H_COEF         = 14'd10000;
    localparam logic [15:0]         T_OFS_CRC      = 16'd4500;
    localparam logic [15:0]         T_OFS_PACKED   = 16'd5000;

    typedef struct packed {
        logic              sensor_type;
        logic              t_ok;
        logic              h_ok;
        logic [WORD_W-1:0] t_word;
        logic [WORD_W-1:0] h_word;
    } t_item;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^32 - 1
    function automatic logic [15:0] div_full_scale(input logic [31:0] x);
        logic [15:0] q0;
        logic [16:0] r;
        q0 = x[31:16];
        r  = {1'b0, x[15:0]} + {1'b0, q0};
        return (r >= {1'b0, FULL_SCALE}) ? q0 + 16'd1 : q0;
    endfunction

endpackage

FILE: rtl/hsfd_front.sv
// front end: sensor type register, frame classification and crc checks
// depends on hsfd_pkg
`timescale 1ns / 1ps

module hsfd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           i_valid,
    input  logic [hsfd_pkg::FRAME_W-1:0]   i_frame_bytes,
    output logic                           o_stall,
    input  logic                           i_queue_full,
    output logic                           o_push,
    output hsfd_pkg::t_item                o_item
);

    logic       r_sensor_type;
    logic [7:0] b0, b1, b2, b3, b4, b5;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_type <= hsfd_pkg::SENSOR_CRC_PAIR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sensor_type <= i_cfg_data;
        end
    end

    assign b0 = i_frame_bytes[47:40];
    assign b1 = i_frame_bytes[39:32];
    assign b2 = i_frame_bytes[31:24];
    assign b3 = i_frame_bytes[23:16];
    assign b4 = i_frame_bytes[15:8];
    assign b5 = i_frame_bytes[7:0];

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_item.sensor_type = r_sensor_type;
        if (r_sensor_type == hsfd_pkg::SENSOR_PACKED) begin
            // busy flag in the top bit of the first byte
            o_item.t_ok   = !b0[7];
            o_item.h_ok   = !b0[7];
            o_item.h_word = i_frame_bytes[39:20];
            o_item.t_word = i_frame_bytes[19:0];
        end else begin
            o_item.t_ok   = hsfd_pkg::crc8_byte(hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, b0), b1)
                            == b2;
            o_item.h_ok   = hsfd_pkg::crc8_byte(hsfd_pkg::crc8_byte(hsfd_pkg::CRC_INIT, b3), b4)
                            == b5;
            o_item.t_word = {4'd0, b0, b1};
            o_item.h_word = {4'd0, b3, b4};
        end
    end

endmodule

FILE: rtl/hsfd_queue.sv
// two-entry queue of classified frames between front and back end
// depends on hsfd_pkg
`timescale 1ns / 1ps

module hsfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hsfd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hsfd_pkg::t_item o_item
);

    hsfd_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

FILE: rtl/hsfd_back.sv
// back end: scaling multiply, fixed point conversion, check counters, output register
// depends on hsfd_pkg
`timescale 1ns / 1ps

module hsfd_back #(
    parameter int COUNT_WIDTH = hsfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  hsfd_pkg::t_item                     i_q_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [hsfd_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [hsfd_pkg::RH_W-1:0]           o_humidity_centi,
    output logic                                o_temperature_ok,
    output logic                                o_humidity_ok,
    output logic                                o_status,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_good_temp_total,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_bad_temp_total,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_good_rh_total,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_bad_rh_total
);

    logic                                r_s1_valid;
    logic                                r_s1_type;
    logic                                r_s1_t_ok;
    logic                                r_s1_h_ok;
    logic [hsfd_pkg::T_PROD_W-1:0]       r_s1_t_prod;
    logic [hsfd_pkg::H_PROD_W-1:0]       r_s1_h_prod;

    logic                                r_out_valid;
    logic signed [hsfd_pkg::TEMP_W-1:0]  r_temp;
    logic [hsfd_pkg::RH_W-1:0]           r_rh;
    logic                                r_t_ok;
    logic                                r_h_ok;
    logic [COUNT_WIDTH-1:0]              r_good_t, r_bad_t, r_good_h, r_bad_h;

    logic                                adv;
    logic [hsfd_pkg::T_COEF_W-1:0]       t_coef;
    logic [hsfd_pkg::T_PROD_W-1:0]       n_t_prod;
    logic [hsfd_pkg::H_PROD_W-1:0]       n_h_prod;
    logic [hsfd_pkg::TEMP_W-1:0]         temp_q;
    logic [hsfd_pkg::RH_W-1:0]           rh_q;
    logic [15:0]                         temp_s;
    logic                                cnt_en;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && i_q_valid;

    // stage 1: scaling multiply
    assign t_coef   = (i_q_item.sensor_type == hsfd_pkg::SENSOR_PACKED) ?
                      hsfd_pkg::T_COEF_PACKED : hsfd_pkg::T_COEF_CRC;
    assign n_t_prod = {{hsfd_pkg::WORD_W{1'b0}}, t_coef}
                      * {{hsfd_pkg::T_COEF_W{1'b0}}, i_q_item.t_word};
    assign n_h_prod = {{hsfd_pkg::WORD_W{1'b0}}, hsfd_pkg::H_COEF}
                      * {{hsfd_pkg::H_COEF_W{1'b0}}, i_q_item.h_word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_type   <= i_q_item.sensor_type;
            r_s1_t_ok   <= i_q_item.t_ok;
            r_s1_h_ok   <= i_q_item.h_ok;
            r_s1_t_prod <= n_t_prod;
            r_s1_h_prod <= n_h_prod;
        end
    end

    // stage 2: divide by full scale or shift, offset
    always_comb begin
        if (r_s1_type == hsfd_pkg::SENSOR_PACKED) begin
            temp_q = r_s1_t_prod[hsfd_pkg::T_PROD_W-1:hsfd_pkg::PACKED_SHIFT];
            rh_q   = r_s1_h_prod[hsfd_pkg::H_PROD_W-1:hsfd_pkg::PACKED_SHIFT];
            temp_s = {1'b0, temp_q} - hsfd_pkg::T_OFS_PACKED;
        end else begin
            temp_q = hsfd_pkg::TEMP_W'(hsfd_pkg::div_full_scale(r_s1_t_prod[31:0]));
            rh_q   = hsfd_pkg::RH_W'(hsfd_pkg::div_full_scale(r_s1_h_prod[31:0]));
            temp_s = {1'b0, temp_q} - hsfd_pkg::T_OFS_CRC;
        end
    end

    assign cnt_en = adv && r_s1_valid && (r_s1_type == hsfd_pkg::SENSOR_CRC_PAIR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_good_t    <= '0;
            r_bad_t     <= '0;
            r_good_h    <= '0;
            r_bad_h     <= '0;
        end else begin
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (cnt_en) begin
                if (r_s1_t_ok) begin
                    r_good_t <= r_good_t + 1'b1;
                end else begin
                    r_bad_t <= r_bad_t + 1'b1;
                end
                if (r_s1_h_ok) begin
                    r_good_h <= r_good_h + 1'b1;
                end else begin
                    r_bad_h <= r_bad_h + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t_ok <= r_s1_t_ok;
            r_h_ok <= r_s1_h_ok;
            r_temp <= r_s1_t_ok ? temp_s[hsfd_pkg::TEMP_W-1:0] : '0;
            r_rh   <= r_s1_h_ok ? rh_q : '0;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_temperature_centi = r_temp;
    assign o_humidity_centi    = r_rh;
    assign o_temperature_ok    = r_t_ok;
    assign o_humidity_ok       = r_h_ok;
    assign o_status            = !(r_t_ok && r_h_ok);
    assign o_good_temp_total   = hsfd_pkg::TOTAL_W'(r_good_t);
    assign o_bad_temp_total    = hsfd_pkg::TOTAL_W'(r_bad_t);
    assign o_good_rh_total     = hsfd_pkg::TOTAL_W'(r_good_h);
    assign o_bad_rh_total      = hsfd_pkg::TOTAL_W'(r_bad_h);

endmodule

FILE: rtl/humidity_sensor_frame_decoder.sv
// humidity sensor frame decoder top level: front end, request queue, back end
// depends on hsfd_pkg, hsfd_front, hsfd_queue, hsfd_back
// a result passes the queue, the stage 1 register and the output register, and waits longer under output stall
// throughput: one frame per cycle while i_stall is low, set by the two-entry queue and the two back end stages
// reset (synchronous, active low): queue empty, pipeline empty, counters zero, sensor type 0
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder #(
    parameter int COUNT_WIDTH = hsfd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_data,
    output logic                                o_cfg_ready,
    input  logic                                i_valid,
    input  logic [hsfd_pkg::FRAME_W-1:0]        i_frame_bytes,
    output logic                                o_stall,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [hsfd_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic [hsfd_pkg::RH_W-1:0]           o_humidity_centi,
    output logic                                o_temperature_ok,
    output logic                                o_humidity_ok,
    output logic                                o_status,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_good_temp_total,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_bad_temp_total,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_good_rh_total,
    output logic [hsfd_pkg::TOTAL_W-1:0]        o_bad_rh_total
);

    logic            push, pop, q_full, q_valid;
    hsfd_pkg::t_item front_item, q_item;

    hsfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_valid       (i_valid),
        .i_frame_bytes (i_frame_bytes),
        .o_stall       (o_stall),
        .i_queue_full  (q_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    hsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    hsfd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_pop               (pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_ok    (o_temperature_ok),
        .o_humidity_ok       (o_humidity_ok),
        .o_status            (o_status),
        .o_good_temp_total   (o_good_temp_total),
        .o_bad_temp_total    (o_bad_temp_total),
        .o_good_rh_total     (o_good_rh_total),
        .o_bad_rh_total      (o_bad_rh_total)
    );

endmodule

FILE: rtl/hsfd_checker.sv
// port-level checks on the humidity sensor frame decoder, bound to the top level
// depends on hsfd_pkg and humidity_sensor_frame_decoder
`timescale 1ns / 1ps

module hsfd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [hsfd_pkg::TEMP_W-1:0]  o_temperature_centi,
    input  logic [hsfd_pkg::RH_W-1:0]           o_humidity_centi,
    input  logic                                o_temperature_ok,
    input  logic                                o_humidity_ok,
    input  logic                                o_status,
    input  logic [hsfd_pkg::TOTAL_W-1:0]        o_good_temp_total,
    input  logic [hsfd_pkg::TOTAL_W-1:0]        o_bad_rh_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature_centi)
                               && $stable(o_good_temp_total) && $stable(o_bad_rh_total))
        else $error("stalled result changed");

    a_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == !(o_temperature_ok && o_humidity_ok)))
        else $error("status disagrees with ok bits");

    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_temperature_ok |-> o_temperature_centi == '0)
        else $error("failed temperature not zero");

    a_rh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_humidity_ok |-> o_humidity_centi == '0)
        else $error("failed humidity not zero");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);
